// ===== design/orm_channel_packer_nearest_resample_core_macros.svh =====
`ifndef ORM_CHANNEL_PACKER_NEAREST_RESAMPLE_CORE_MACROS_SVH
`define ORM_CHANNEL_PACKER_NEAREST_RESAMPLE_CORE_MACROS_SVH

// Assertion that a condition implies a consequence in the same cycle.
`define OCPNR_ASSERT_SAME(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("ocpnr assertion failed");

// Assertion that a condition implies a consequence in the next cycle.
`define OCPNR_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("ocpnr assertion failed");

`endif

// ===== design/ocpnr_pkg.sv =====
`default_nettype none
package ocpnr_pkg;

    localparam int SIDE_W     = 9;
    localparam int MAX_SIDE   = 256;
    localparam int COORD_W    = 8;
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 16;
    localparam int MAP_DEPTH  = 65536;
    localparam int NUM_MAPS   = 3;
    localparam int NUM_LANES  = 6;
    localparam int DIV_STEPS  = 8;
    localparam int PROD_W     = 16;
    localparam int CFG_ADDR_W = 3;

    // Pipeline positions: input, multiply, divide steps, address, output.
    localparam int ST_MULT    = 1;
    localparam int ST_ADDR    = ST_MULT + DIV_STEPS + 1;
    localparam int ST_OUT     = ST_ADDR + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [1:0] MAP_OCCL  = 2'd0;
    localparam logic [1:0] MAP_ROUGH = 2'd1;
    localparam logic [1:0] MAP_METAL = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_OCCL_W   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OCCL_H   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROUGH_W  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROUGH_H  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_METAL_W  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_METAL_H  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT   = 3'd6;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_MAP  = 2'd1,
        STATUS_OUTSIDE = 2'd2
    } status_t;

    typedef struct packed {
        logic                op;
        logic [1:0]          sel;
        logic [ADDR_W-1:0]   idx;
        logic [PIX_W-1:0]    val;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        status_t             st;
    } meta_t;

    typedef struct packed {
        logic [PROD_W-1:0]  num;
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] quo;
    } div_lane_t;

    // One restoring division step producing quotient bit bitpos.
    function automatic div_lane_t div_step(input div_lane_t lane, input logic [2:0] bitpos,
                                           input logic [SIDE_W-1:0] d);
        logic [COORD_W+1:0] t;
        div_lane_t          res;
        res = lane;
        t   = {1'b0, lane.rem, lane.num[bitpos]};
        if (t >= {1'b0, d}) begin
            res.rem         = COORD_W'(t - {1'b0, d});
            res.quo[bitpos] = 1'b1;
        end else begin
            res.rem = t[COORD_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
        return (v > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : v;
    endfunction

endpackage
`default_nettype wire

// ===== design/orm_channel_packer_nearest_resample_core.sv =====
// Packs occlusion, roughness and metal maps into one RGBA word per pixel.
// Input words on s_axis: tuser selects a sample load or a pixel request.
// A load writes one 8-bit sample into the chosen map and yields no word.
// A pixel request yields one word on m_axis: R, G, B, A in tdata and the
// status in tuser. Map sizes and the roughness inversion are set through
// the cfg_* write port; the user must write them only while no pixel
// request is in flight (the block does not enforce this). Each map scales
// by nearest neighbour through six pipelined 8-step restoring dividers,
// one per map and axis, so a new word is taken every cycle unless stalled.
// Each map is one synchronous RAM, read or written once per cycle at the
// same pipeline position, so loads and reads stay in order.
// Reset clears the size registers and pipeline valids; map contents stay
// undefined until loaded. When m_axis_tready is low with a word waiting,
// the whole pipeline holds and s_axis_tready drops in the same cycle.
`default_nettype none
module orm_channel_packer_nearest_resample_core
    import ocpnr_pkg::*;
(
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [ocpnr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ocpnr_pkg::SIDE_W-1:0]     cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // sample_index[15:0], sample_value[23:16], out_x[31:24], out_y[39:32]
    input  wire logic [39:0]                      s_axis_tdata,
    // opcode[0], map_select[2:1]
    input  wire logic [2:0]                       s_axis_tuser,
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // red_occl[7:0], green_rough[15:8], blue_metal[23:16], alpha_out[31:24]
    output      logic [31:0]                      m_axis_tdata,
    // status[1:0]
    output      logic [1:0]                       m_axis_tuser
);
    `include "orm_channel_packer_nearest_resample_core_macros.svh"

    logic [SIDE_W-1:0] dim_w_reg [NUM_MAPS];
    logic [SIDE_W-1:0] dim_h_reg [NUM_MAPS];
    logic              invert_reg;

    logic              vld_reg  [NUM_STAGES];
    meta_t             meta_reg [NUM_STAGES];
    div_lane_t         lane_reg [DIV_STEPS+1][NUM_LANES];
    logic [ADDR_W-1:0] addr_reg [NUM_MAPS];
    logic [PIX_W-1:0]  rd_reg   [NUM_MAPS];

    logic [PIX_W-1:0]  occl_mem  [MAP_DEPTH];
    logic [PIX_W-1:0]  rough_mem [MAP_DEPTH];
    logic [PIX_W-1:0]  metal_mem [MAP_DEPTH];

    logic              present [NUM_MAPS];
    logic [SIDE_W-1:0] out_w, out_h;
    logic              advance;
    meta_t             in_meta;
    meta_t             stage1_meta;
    status_t           st_calc;
    logic [PIX_W-1:0]  red, green, blue, rough_raw;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < NUM_MAPS; m++) begin
                dim_w_reg[m] <= '0;
                dim_h_reg[m] <= '0;
            end
            invert_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_OCCL_W:  dim_w_reg[0] <= sat_side(cfg_wdata);
                REG_OCCL_H:  dim_h_reg[0] <= sat_side(cfg_wdata);
                REG_ROUGH_W: dim_w_reg[1] <= sat_side(cfg_wdata);
                REG_ROUGH_H: dim_h_reg[1] <= sat_side(cfg_wdata);
                REG_METAL_W: dim_w_reg[2] <= sat_side(cfg_wdata);
                REG_METAL_H: dim_h_reg[2] <= sat_side(cfg_wdata);
                REG_INVERT:  invert_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Output size is the largest present width and height.
    always_comb begin
        out_w = '0;
        out_h = '0;
        for (int m = 0; m < NUM_MAPS; m++) begin
            present[m] = (dim_w_reg[m] != '0) && (dim_h_reg[m] != '0);
            if (present[m] && dim_w_reg[m] > out_w) out_w = dim_w_reg[m];
            if (present[m] && dim_h_reg[m] > out_h) out_h = dim_h_reg[m];
        end
    end

    assign advance       = !vld_reg[ST_OUT] || m_axis_tready;
    assign s_axis_tready = advance;

    always_comb begin
        in_meta.op  = s_axis_tuser[0];
        in_meta.sel = s_axis_tuser[2:1];
        in_meta.idx = s_axis_tdata[15:0];
        in_meta.val = s_axis_tdata[23:16];
        in_meta.x   = s_axis_tdata[31:24];
        in_meta.y   = s_axis_tdata[39:32];
        in_meta.st  = STATUS_OK;
    end

    always_comb begin
        priority if (out_w == '0 || out_h == '0) begin
            st_calc = STATUS_NO_MAP;
        end else if ({1'b0, meta_reg[0].x} >= out_w || {1'b0, meta_reg[0].y} >= out_h) begin
            st_calc = STATUS_OUTSIDE;
        end else begin
            st_calc = STATUS_OK;
        end
    end

    always_comb begin
        stage1_meta    = meta_reg[0];
        stage1_meta.st = st_calc;
    end

    // Pipeline valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_STAGES; s++) vld_reg[s] <= 1'b0;
        end else if (advance) begin
            vld_reg[0] <= s_axis_tvalid;
            for (int s = 1; s < ST_OUT; s++) vld_reg[s] <= vld_reg[s-1];
            // Loads end at the memory stage and leave no word behind.
            vld_reg[ST_OUT] <= vld_reg[ST_ADDR] && (meta_reg[ST_ADDR].op == OP_PIXEL);
        end
    end

    // Pipeline payload: multiply, divide steps and address forming.
    always_ff @(posedge aclk) begin
        if (advance) begin
            meta_reg[0] <= in_meta;
            meta_reg[1] <= stage1_meta;
            for (int s = 2; s < NUM_STAGES; s++) meta_reg[s] <= meta_reg[s-1];

            for (int l = 0; l < NUM_LANES; l++) begin
                if (l % 2 == 0) begin
                    lane_reg[0][l].num <= PROD_W'(meta_reg[0].x * dim_w_reg[l/2]);
                    lane_reg[0][l].rem <= COORD_W'(PROD_W'(meta_reg[0].x * dim_w_reg[l/2])
                                                   >> COORD_W);
                end else begin
                    lane_reg[0][l].num <= PROD_W'(meta_reg[0].y * dim_h_reg[l/2]);
                    lane_reg[0][l].rem <= COORD_W'(PROD_W'(meta_reg[0].y * dim_h_reg[l/2])
                                                   >> COORD_W);
                end
                lane_reg[0][l].quo <= '0;
            end

            for (int j = 0; j < DIV_STEPS; j++) begin
                for (int l = 0; l < NUM_LANES; l++) begin
                    lane_reg[j+1][l] <= div_step(lane_reg[j][l], 3'(DIV_STEPS-1-j),
                                                 (l % 2 == 0) ? out_w : out_h);
                end
            end

            for (int m = 0; m < NUM_MAPS; m++) begin
                addr_reg[m] <= ADDR_W'(lane_reg[DIV_STEPS][2*m+1].quo * dim_w_reg[m]
                               + lane_reg[DIV_STEPS][2*m].quo);
            end
        end
    end

    // Map memories: one write or one read per cycle at the address stage.
    always_ff @(posedge aclk) begin
        if (advance && vld_reg[ST_ADDR]) begin
            if (meta_reg[ST_ADDR].op == OP_LOAD) begin
                if (meta_reg[ST_ADDR].sel == MAP_OCCL) begin
                    occl_mem[meta_reg[ST_ADDR].idx] <= meta_reg[ST_ADDR].val;
                end
            end else begin
                rd_reg[0] <= occl_mem[addr_reg[0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && vld_reg[ST_ADDR]) begin
            if (meta_reg[ST_ADDR].op == OP_LOAD) begin
                if (meta_reg[ST_ADDR].sel == MAP_ROUGH) begin
                    rough_mem[meta_reg[ST_ADDR].idx] <= meta_reg[ST_ADDR].val;
                end
            end else begin
                rd_reg[1] <= rough_mem[addr_reg[1]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && vld_reg[ST_ADDR]) begin
            if (meta_reg[ST_ADDR].op == OP_LOAD) begin
                if (meta_reg[ST_ADDR].sel == MAP_METAL) begin
                    metal_mem[meta_reg[ST_ADDR].idx] <= meta_reg[ST_ADDR].val;
                end
            end else begin
                rd_reg[2] <= metal_mem[addr_reg[2]];
            end
        end
    end

    // Result word.
    always_comb begin
        rough_raw = invert_reg ? (PIX_FULL - rd_reg[1]) : rd_reg[1];
        if (meta_reg[ST_OUT].st == STATUS_OK) begin
            red   = present[0] ? rd_reg[0] : PIX_FULL;
            green = present[1] ? rough_raw : PIX_FULL;
            blue  = present[2] ? rd_reg[2] : '0;
        end else begin
            red   = '0;
            green = '0;
            blue  = '0;
        end
    end

    assign m_axis_tvalid = vld_reg[ST_OUT];
    assign m_axis_tdata  = {PIX_FULL, blue, green, red};
    assign m_axis_tuser  = meta_reg[ST_OUT].st;

    `OCPNR_ASSERT_SAME(a_stall_blocks_input, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `OCPNR_ASSERT_SAME(a_ok_inside_output, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser == STATUS_OK,
        ({1'b0, meta_reg[ST_OUT].x} < out_w) && ({1'b0, meta_reg[ST_OUT].y} < out_h))
    `OCPNR_ASSERT_NEXT(a_load_gives_no_word, aclk, aresetn,
        advance && vld_reg[ST_ADDR] && meta_reg[ST_ADDR].op == OP_LOAD, !m_axis_tvalid)

endmodule
`default_nettype wire
